/* rtl/prmv_pkg.sv */
// ----------------------------------------------------------------------------
// prmv_pkg
// Shared widths, defaults and helpers for the running mean/variance block.
// ----------------------------------------------------------------------------
package prmv_pkg;

	localparam int unsigned STORE_DEPTH_DEF   = 65536;
	localparam int unsigned FRACTION_BITS_DEF = 8;

	localparam int unsigned SAMPLE_W  = 17;
	localparam int unsigned INDEX_W   = 16;
	localparam int unsigned WINDOW_W  = 16;
	localparam int unsigned COUNT_W   = 32;
	localparam int unsigned DIVISOR_W = COUNT_W + 1;
	localparam int unsigned MEAN_W    = 25;
	localparam int unsigned VAR_W     = 40;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -17'sd32768;

	function automatic int unsigned addr_width(input int unsigned depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

/* rtl/prmv_store.sv */
// ----------------------------------------------------------------------------
// prmv_store
// Per-pixel mean and mean-of-squares memories with a zeroing pass after reset.
// ----------------------------------------------------------------------------
module prmv_store #(
	parameter int unsigned DEPTH = prmv_pkg::STORE_DEPTH_DEF,
	parameter int unsigned AW    = prmv_pkg::addr_width(DEPTH),
	parameter int unsigned MW    = 26,
	parameter int unsigned SW    = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic signed [MW-1:0] rd_mean,
	output logic [SW-1:0]        rd_sq,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic signed [MW-1:0] wr_mean,
	input  logic [SW-1:0]        wr_sq,
	output logic                 busy
);

	logic signed [MW-1:0] mem_m [DEPTH];
	logic [SW-1:0]        mem_s [DEPTH];

	logic                 busy_q;
	logic [AW-1:0]        clr_cnt_q;
	logic                 we;
	logic [AW-1:0]        wa;
	logic signed [MW-1:0] wdm;
	logic [SW-1:0]        wds;
	logic signed [MW-1:0] rd_m_q;
	logic [SW-1:0]        rd_s_q;

	// sweep zeros through every entry once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_cnt_q <= '0;
		end else if (busy_q) begin
			clr_cnt_q <= AW'(clr_cnt_q + 1'b1);
			if (clr_cnt_q == AW'(DEPTH - 1))
				busy_q <= 1'b0;
		end
	end

	assign we  = busy_q | wr_en;
	assign wa  = busy_q ? clr_cnt_q : wr_addr;
	assign wdm = busy_q ? '0 : wr_mean;
	assign wds = busy_q ? '0 : wr_sq;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_m[wa] <= wdm;
			mem_s[wa] <= wds;
		end
		if (rd_en) begin
			rd_m_q <= mem_m[rd_addr];
			rd_s_q <= mem_s[rd_addr];
		end
	end

	assign rd_mean = rd_m_q;
	assign rd_sq   = rd_s_q;
	assign busy    = busy_q;

endmodule

/* rtl/prmv_div.sv */
// ----------------------------------------------------------------------------
// prmv_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module prmv_div #(
	parameter int unsigned DW = 41,
	parameter int unsigned NW = prmv_pkg::DIVISOR_W
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] a,
	input  logic [NW-1:0] n,
	output logic [DW-1:0] q
);

	logic [NW-1:0] rem_s [DW];
	logic [DW-1:0] aq_s  [DW];
	logic [NW-1:0] n_s   [DW];

	logic [NW-1:0] rem_nx [DW];
	logic [DW-1:0] aq_nx  [DW];
	logic [NW-1:0] n_nx   [DW];

	always_comb begin
		logic [NW-1:0] rem_p;
		logic [DW-1:0] aq_p;
		logic [NW-1:0] n_p;
		logic [NW:0]   raw;
		logic          ge;
		for (int j = 0; j < DW; j++) begin
			if (j == 0) begin
				rem_p = '0;
				aq_p  = a;
				n_p   = n;
			end else begin
				rem_p = rem_s[j-1];
				aq_p  = aq_s[j-1];
				n_p   = n_s[j-1];
			end
			// partial remainder stays below the divisor, so it fits NW bits
			raw       = {rem_p, aq_p[DW-1]};
			ge        = raw >= {1'b0, n_p};
			rem_nx[j] = ge ? NW'(raw - {1'b0, n_p}) : raw[NW-1:0];
			aq_nx[j]  = {aq_p[DW-2:0], ge};
			n_nx[j]   = n_p;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < DW; j++) begin
				rem_s[j] <= rem_nx[j];
				aq_s[j]  <= aq_nx[j];
				n_s[j]   <= n_nx[j];
			end
		end
	end

	assign q = aq_s[DW-1];

endmodule

/* rtl/pixel_running_mean_variance_top.sv */
// ----------------------------------------------------------------------------
// pixel_running_mean_variance_top
// Per-pixel running mean and variance over a frame stream.
// ----------------------------------------------------------------------------
// Takes one sample transaction per clock when not held off and returns one
// result per sample, in order. The pipeline has two stages for the store
// read and the differences, one stage per quotient bit of the divider on
// (k+1), then three stages for the step, the square and the output
// register. The input holds off while an earlier sample with the same
// pixel_index has not yet written its store entry, and after reset while
// the stores are swept to zero. A stalled output freezes the whole pipeline.
// ----------------------------------------------------------------------------
module pixel_running_mean_variance_top #(
	parameter int unsigned PIXEL_STORE_DEPTH = prmv_pkg::STORE_DEPTH_DEF,
	parameter int unsigned FRACTION_BITS     = prmv_pkg::FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [prmv_pkg::WINDOW_W-1:0]        cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [prmv_pkg::SAMPLE_W-1:0] sample,
	input  logic [prmv_pkg::INDEX_W-1:0]         pixel_index,
	input  logic                                 frame_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [prmv_pkg::MEAN_W-1:0]   mean,
	output logic [prmv_pkg::VAR_W-1:0]           variance,
	output logic                                 last_of_frame
);

	localparam int unsigned XW = prmv_pkg::SAMPLE_W;
	localparam int unsigned IW = prmv_pkg::INDEX_W;
	localparam int unsigned NW = prmv_pkg::DIVISOR_W;
	localparam int unsigned AW = prmv_pkg::addr_width(PIXEL_STORE_DEPTH);
	localparam int unsigned MW = XW + FRACTION_BITS + 1;
	localparam int unsigned SW = 2 * (XW - 1) + FRACTION_BITS;
	localparam int unsigned DW = SW + 1;
	localparam int unsigned PW = 2 * (MW - 1);
	localparam int unsigned VW = PW + 1;

	logic adv, busy, hz, accept;

	logic [prmv_pkg::WINDOW_W-1:0] window_q;
	logic [prmv_pkg::COUNT_W-1:0]  fc_q;

	// ---------------- input stage ----------------
	logic signed [XW-1:0]     x_in;
	logic signed [2*XW-1:0]   x2_in;
	logic [prmv_pkg::COUNT_W-1:0] k_in;
	logic [NW-1:0]            n_in;

	assign x_in  = (sample < prmv_pkg::SAMPLE_MIN) ? prmv_pkg::SAMPLE_MIN : sample;
	assign x2_in = x_in * x_in;
	assign k_in  = (window_q != '0) ? prmv_pkg::COUNT_W'(window_q) : fc_q;
	assign n_in  = NW'(k_in) + NW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fc_q     <= '0;
		end else begin
			if (cfg_wr_en)
				window_q <= cfg_wr_data;
			if (accept && frame_end)
				fc_q <= fc_q + 1'b1;
		end
	end

	// ---------------- stage 1: store read data ----------------
	logic                 v_s1, ins_s1, last_s1;
	logic signed [XW-1:0] x_s1;
	logic [SW-1:0]        sq_s1;
	logic [IW-1:0]        idx_s1;
	logic [NW-1:0]        n_s1;
	logic signed [MW-1:0] rd_m;
	logic [SW-1:0]        rd_s;
	logic                 ins_in;

	assign ins_in = 32'(pixel_index) < 32'(PIXEL_STORE_DEPTH);

	// ---------------- stage 2: differences ----------------
	logic                 v_s2, ins_s2, last_s2;
	logic signed [MW:0]   dm_s2;
	logic signed [SW:0]   ds_s2;
	logic signed [MW-1:0] om_s2;
	logic [SW-1:0]        os_s2;
	logic [IW-1:0]        idx_s2;
	logic [NW-1:0]        n_s2;

	logic signed [MW-1:0] old_m;
	logic [SW-1:0]        old_s;
	logic signed [MW:0]   xq;

	assign old_m = ins_s1 ? rd_m : '0;
	assign old_s = ins_s1 ? rd_s : '0;
	assign xq    = (MW+1)'(x_s1) <<< FRACTION_BITS;

	// ---------------- divider sideband ----------------
	logic                 dv_s   [DW];
	logic                 dins_s [DW];
	logic                 dlast_s[DW];
	logic                 dsgm_s [DW];
	logic                 dsgs_s [DW];
	logic [IW-1:0]        didx_s [DW];
	logic signed [MW-1:0] dom_s  [DW];
	logic [SW-1:0]        dos_s  [DW];

	logic [MW-1:0] magm;
	logic [SW-1:0] mags;
	logic [DW-1:0] am, as_in, qm, qs;

	assign magm  = dm_s2[MW] ? MW'(-dm_s2) : MW'(dm_s2);
	assign mags  = ds_s2[SW] ? SW'(-ds_s2) : SW'(ds_s2);
	assign am    = DW'(magm) + DW'(n_s2 >> 1);
	assign as_in = DW'(mags) + DW'(n_s2 >> 1);

	prmv_div #(.DW(DW), .NW(NW)) u_div_mean (
		.clk (clk),
		.en  (adv),
		.a   (am),
		.n   (n_s2),
		.q   (qm)
	);

	prmv_div #(.DW(DW), .NW(NW)) u_div_sq (
		.clk (clk),
		.en  (adv),
		.a   (as_in),
		.n   (n_s2),
		.q   (qs)
	);

	// ---------------- apply rounded step ----------------
	logic signed [MW-1:0] new_m;
	logic [SW-1:0]        new_s;
	logic                 wr_en;

	assign new_m = dsgm_s[DW-1] ? MW'(dom_s[DW-1] - MW'(qm)) : MW'(dom_s[DW-1] + MW'(qm));
	assign new_s = dsgs_s[DW-1] ? SW'(dos_s[DW-1] - SW'(qs)) : SW'(dos_s[DW-1] + SW'(qs));
	assign wr_en = adv && dv_s[DW-1] && dins_s[DW-1];

	prmv_store #(.DEPTH(PIXEL_STORE_DEPTH), .AW(AW), .MW(MW), .SW(SW)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (AW'(pixel_index)),
		.rd_mean (rd_m),
		.rd_sq   (rd_s),
		.wr_en   (wr_en),
		.wr_addr (AW'(didx_s[DW-1])),
		.wr_mean (new_m),
		.wr_sq   (new_s),
		.busy    (busy)
	);

	// ---------------- post stages ----------------
	logic                 v_sp, last_sp;
	logic signed [MW-1:0] nm_sp;
	logic [SW-1:0]        ns_sp;
	logic [MW-2:0]        mm;

	logic                 v_sq, last_sq;
	logic signed [MW-1:0] nm_sq;
	logic [SW-1:0]        ns_sq;
	logic [PW-1:0]        mm2_sq;

	logic signed [VW-1:0] var_d;
	logic [PW-1:0]        msq;

	assign mm    = nm_sp[MW-1] ? (MW-1)'(-nm_sp) : (MW-1)'(nm_sp);
	assign msq   = mm2_sq >> FRACTION_BITS;
	assign var_d = signed'(VW'(ns_sq)) - signed'(VW'(msq));

	logic                              out_valid_q, last_q;
	logic signed [prmv_pkg::MEAN_W-1:0] mean_q;
	logic [prmv_pkg::VAR_W-1:0]        var_q;

	// ---------------- flow control ----------------
	assign adv = !out_valid_q || out_ready;

	// hold off a pixel whose store entry is still being updated downstream
	always_comb begin
		hz = (v_s1 && ins_s1 && idx_s1 == pixel_index) ||
		     (v_s2 && ins_s2 && idx_s2 == pixel_index);
		for (int i = 0; i < DW; i++) begin
			if (dv_s[i] && dins_s[i] && didx_s[i] == pixel_index)
				hz = 1'b1;
		end
		hz = hz && ins_in;
	end

	assign in_ready = adv && !busy && !hz;
	assign accept   = in_valid && in_ready;

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_sp        <= 1'b0;
			v_sq        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DW; i++)
				dv_s[i] <= 1'b0;
		end else if (adv) begin
			v_s1        <= accept;
			v_s2        <= v_s1;
			dv_s[0]     <= v_s2;
			for (int i = 1; i < DW; i++)
				dv_s[i] <= dv_s[i-1];
			v_sp        <= dv_s[DW-1];
			v_sq        <= v_sp;
			out_valid_q <= v_sq;
		end
	end

	// ---------------- payload ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= x_in;
			sq_s1   <= SW'(unsigned'(x2_in)) << FRACTION_BITS;
			idx_s1  <= pixel_index;
			ins_s1  <= ins_in;
			last_s1 <= frame_end;
			n_s1    <= n_in;

			dm_s2   <= xq - (MW+1)'(old_m);
			ds_s2   <= signed'((SW+1)'(sq_s1)) - signed'((SW+1)'(old_s));
			om_s2   <= old_m;
			os_s2   <= old_s;
			idx_s2  <= idx_s1;
			ins_s2  <= ins_s1;
			last_s2 <= last_s1;
			n_s2    <= n_s1;

			dins_s[0]  <= ins_s2;
			dlast_s[0] <= last_s2;
			dsgm_s[0]  <= dm_s2[MW];
			dsgs_s[0]  <= ds_s2[SW];
			didx_s[0]  <= idx_s2;
			dom_s[0]   <= om_s2;
			dos_s[0]   <= os_s2;
			for (int i = 1; i < DW; i++) begin
				dins_s[i]  <= dins_s[i-1];
				dlast_s[i] <= dlast_s[i-1];
				dsgm_s[i]  <= dsgm_s[i-1];
				dsgs_s[i]  <= dsgs_s[i-1];
				didx_s[i]  <= didx_s[i-1];
				dom_s[i]   <= dom_s[i-1];
				dos_s[i]   <= dos_s[i-1];
			end

			nm_sp   <= new_m;
			ns_sp   <= new_s;
			last_sp <= dlast_s[DW-1];

			nm_sq   <= nm_sp;
			ns_sq   <= ns_sp;
			mm2_sq  <= PW'(mm * mm);
			last_sq <= last_sp;

			mean_q  <= prmv_pkg::MEAN_W'(nm_sq);
			// clamp negative variance to zero
			var_q   <= var_d[VW-1] ? '0 : prmv_pkg::VAR_W'(unsigned'(var_d));
			last_q  <= last_sq;
		end
	end

	assign out_valid     = out_valid_q;
	assign mean          = mean_q;
	assign variance      = var_q;
	assign last_of_frame = last_q;

endmodule

/* rtl/prmv_checker.sv */
// ----------------------------------------------------------------------------
// prmv_checker
// Port-level checks for the running mean/variance block.
// ----------------------------------------------------------------------------
module prmv_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 cfg_wr_en,
	input logic [prmv_pkg::WINDOW_W-1:0]        cfg_wr_data,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic signed [prmv_pkg::SAMPLE_W-1:0] sample,
	input logic [prmv_pkg::INDEX_W-1:0]         pixel_index,
	input logic                                 frame_end,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [prmv_pkg::MEAN_W-1:0]   mean,
	input logic [prmv_pkg::VAR_W-1:0]           variance,
	input logic                                 last_of_frame
);

	logic [7:0] in_flight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_flight_q <= '0;
		else
			in_flight_q <= 8'(in_flight_q + 8'(in_valid && in_ready)
			                  - 8'(out_valid && out_ready));
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean) && $stable(variance)
		&& $stable(last_of_frame))
		else $error("result changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_flight_q != 8'd0)
		else $error("result without a pending sample");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while pipeline frozen");

endmodule

bind pixel_running_mean_variance_top prmv_checker u_prmv_checker (.*);

/* verif/pixel_running_mean_variance_top_test.sv */
// ----------------------------------------------------------------------------
// pixel_running_mean_variance_top_test
// Checks the per-pixel running mean/variance block against a local predictor.
// ----------------------------------------------------------------------------
// Directed samples cover the sample range ends, the saturating low end, the
// first cumulative frame and the last store entry. Random phases then send
// frames of consecutive pixels under several window settings. Each accepted
// transaction is predicted in order, and every result is compared field by
// field. Both sides stall at random, with bursts of no stalls in between.
// ----------------------------------------------------------------------------
module pixel_running_mean_variance_top_test;

	localparam int unsigned SAMPLE_W   = prmv_pkg::SAMPLE_W;
	localparam int unsigned INDEX_W    = prmv_pkg::INDEX_W;
	localparam int unsigned WINDOW_W   = prmv_pkg::WINDOW_W;
	localparam int unsigned MEAN_W     = prmv_pkg::MEAN_W;
	localparam int unsigned VAR_W      = prmv_pkg::VAR_W;
	localparam int unsigned FRAC       = prmv_pkg::FRACTION_BITS_DEF;
	localparam int unsigned DEPTH      = prmv_pkg::STORE_DEPTH_DEF;
	localparam int unsigned CYCLE_CAP  = 600000;
	localparam int unsigned DRAIN_WAIT = 60;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [INDEX_W-1:0]         pixel_index;
		logic                       frame_end;
	} pixel_t;

	typedef struct packed {
		logic signed [MEAN_W-1:0] mean;
		logic [VAR_W-1:0]         variance;
		logic                     last_of_frame;
	} stats_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [WINDOW_W-1:0]        cfg_wr_data;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic [INDEX_W-1:0]         pixel_index;
	logic                       frame_end;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [MEAN_W-1:0]   mean;
	logic [VAR_W-1:0]           variance;
	logic                       last_of_frame;

	pixel_running_mean_variance_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.pixel_index  (pixel_index),
		.frame_end    (frame_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mean         (mean),
		.variance     (variance),
		.last_of_frame(last_of_frame)
	);

	pixel_t      pending_pixels[$];
	stats_t      expected_stats[$];
	longint      mean_mem[DEPTH];
	longint      square_mem[DEPTH];
	logic [31:0] frames_done = '0;
	logic [15:0] window_k = '0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	bit          in_fire = 0;
	bit          out_fire = 0;
	bit          no_stall = 0;

	initial clk = 0;
	always #4 clk = ~clk;

	// round(d / n) to nearest, ties away from zero
	function automatic longint round_div(input longint d, input longint unsigned n);
		longint unsigned mag;
		longint unsigned q;
		mag = (d < 0) ? longint'(-d) : longint'(d);
		q = (mag + n / 2) / n;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic stats_t update_pixel(input pixel_t p);
		longint          x, old_m, old_s, new_m, new_s, var_q;
		longint unsigned n, mag;
		stats_t          r;
		x = longint'(p.sample);
		if (x < -32768)
			x = -32768;
		n = (window_k != 0) ? longint'(window_k) + 1 : longint'(frames_done) + 1;
		old_m = mean_mem[p.pixel_index];
		old_s = square_mem[p.pixel_index];
		new_m = old_m + round_div((x <<< FRAC) - old_m, n);
		new_s = old_s + round_div(((x * x) <<< FRAC) - old_s, n);
		mean_mem[p.pixel_index] = new_m;
		square_mem[p.pixel_index] = new_s;
		mag = (new_m < 0) ? -new_m : new_m;
		var_q = new_s - longint'((mag * mag) >> FRAC);
		if (var_q < 0)
			var_q = 0;
		if (p.frame_end)
			frames_done = frames_done + 1;
		r.mean = new_m[MEAN_W-1:0];
		r.variance = var_q[VAR_W-1:0];
		r.last_of_frame = p.frame_end;
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] draw_sample();
		case ($urandom_range(0, 3))
			0: return SAMPLE_W'($urandom);
			1: return SAMPLE_W'($urandom_range(0, 255));
			2: return SAMPLE_W'($urandom_range(0, 65535));
			default: return SAMPLE_W'(int'($urandom_range(0, 65535)) - 32768);
		endcase
	endfunction

	task automatic queue_pixel(input logic signed [SAMPLE_W-1:0] s,
			input logic [INDEX_W-1:0] idx, input logic last);
		pixel_t p;
		p.sample = s;
		p.pixel_index = idx;
		p.frame_end = last;
		pending_pixels.push_back(p);
	endtask

	task automatic queue_frames(input int unsigned count);
		int unsigned width;
		logic [INDEX_W-1:0] base;
		int unsigned sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: stray pixel anywhere in the store
				queue_pixel(draw_sample(), INDEX_W'($urandom), 1'($urandom_range(0, 1)));
				sent++;
			end else begin
				width = $urandom_range(1, 16);
				base = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom) : '0;
				for (int unsigned i = 0; i < width; i++)
					queue_pixel(draw_sample(), base + INDEX_W'(i), i == width - 1);
				sent += width;
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_pixels.size() != 0 || in_valid || expected_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_window(input logic [WINDOW_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		window_k = value;
	endtask

	// Monitor: predict accepted samples, check delivered results
	always @(posedge clk) begin
		stats_t want;
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("FAILURE");
			$finish;
		end else begin
			if (in_valid && in_ready) begin
				expected_stats.push_back(update_pixel({sample, pixel_index, frame_end}));
				in_fire = 1;
			end
			if (out_valid && out_ready) begin
				out_fire = 1;
				if (expected_stats.size() == 0) begin
					$display("%0t: unexpected result mean=%0d variance=%0d", $time,
						mean, variance);
					error_count++;
				end else begin
					want = expected_stats.pop_front();
					if (mean !== want.mean) begin
						$display("%0t: mean expected %0d actual %0d", $time, want.mean, mean);
						error_count++;
					end
					if (variance !== want.variance) begin
						$display("%0t: variance expected %0d actual %0d", $time,
							want.variance, variance);
						error_count++;
					end
					if (last_of_frame !== want.last_of_frame) begin
						$display("%0t: last_of_frame expected %0b actual %0b", $time,
							want.last_of_frame, last_of_frame);
						error_count++;
					end
				end
			end
		end
	end

	// Driver: hold each transaction until accepted, then gap before the next
	int unsigned in_gap = 0;
	int unsigned out_wait = 0;
	int unsigned burst_left = 0;

	always @(negedge clk) begin
		pixel_t p;
		logic   next_valid;
		if (arst_n) begin
			next_valid = in_valid;
			if (in_fire) begin
				next_valid = 0;
				in_fire = 0;
			end
			if (!next_valid) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (pending_pixels.size() != 0) begin
					p = pending_pixels.pop_front();
					sample <= p.sample;
					pixel_index <= p.pixel_index;
					frame_end <= p.frame_end;
					next_valid = 1;
					if (burst_left > 0)
						burst_left--;
					else if ($urandom_range(0, 29) == 0)
						burst_left = $urandom_range(20, 60);
					no_stall = burst_left > 0;
					in_gap = no_stall ? 0 : $urandom_range(0, 8);
				end
			end
			in_valid <= next_valid;
			if (out_fire) begin
				out_fire = 0;
				out_wait = no_stall ? 0 : $urandom_range(0, 8);
			end
			if (out_wait > 0) begin
				out_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [WINDOW_W-1:0] windows[5];
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = '0;
		in_valid = 0;
		sample = '0;
		pixel_index = '0;
		frame_end = 0;
		out_ready = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		write_window('0);
		// first cumulative frame: each mean is its clamped sample in fixed point, variance zero
		queue_pixel(17'sd0, 16'd0, 1'b0);
		queue_pixel(17'sd65535, 16'd65535, 1'b0);
		queue_pixel(-17'sd65536, 16'd1, 1'b0);
		queue_pixel(-17'sd32769, 16'd2, 1'b0);
		queue_pixel(-17'sd32768, 16'd3, 1'b0);
		queue_pixel(17'sd32767, 16'd4, 1'b0);
		queue_pixel(-17'sd1, 16'd5, 1'b0);
		queue_pixel(17'sd255, 16'h5555, 1'b0);
		queue_pixel(17'sd1, 16'haaaa, 1'b1);
		// second frame over pixels 0 to 5 and 65535: mean of two, then two one-pixel frames
		queue_pixel(17'sd1, 16'd0, 1'b0);
		queue_pixel(17'sd0, 16'd65535, 1'b0);
		queue_pixel(17'sd65535, 16'd1, 1'b0);
		queue_pixel(-17'sd32768, 16'd2, 1'b0);
		queue_pixel(17'sd3, 16'd3, 1'b0);
		queue_pixel(-17'sd32767, 16'd4, 1'b0);
		queue_pixel(-17'sd2, 16'd5, 1'b1);
		queue_pixel(17'sd7, 16'd0, 1'b1);
		queue_pixel(-17'sd7, 16'd0, 1'b1);
		wait_idle();

		windows[0] = 16'd1;
		windows[1] = 16'd65535;
		windows[2] = WINDOW_W'($urandom_range(2, 40));
		windows[3] = 16'd0;
		windows[4] = WINDOW_W'($urandom);
		queue_frames(240);
		wait_idle();
		foreach (windows[i]) begin
			write_window(windows[i]);
			queue_frames(230);
			wait_idle();
		end

		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
